// ----- hdl/lt_kwm_pkg.sv -----
package lt_kwm_pkg;

	localparam int MAX_WAYS  = 8;
	localparam int RUN_DEPTH = 128;
	localparam int KEY_BITS  = 16;

	localparam int WAY_W  = $clog2(MAX_WAYS);
	localparam int LEAF_W = $clog2(MAX_WAYS + 1);
	localparam int PTR_W  = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
	localparam int LEN_W  = $clog2(RUN_DEPTH + 1);
	localparam int ADDR_W = WAY_W + PTR_W;
	localparam int LKEY_W = KEY_BITS + 1;
	localparam int CNT_W  = $clog2(MAX_WAYS * RUN_DEPTH + 1);

	// fixed field widths
	localparam int CFG_W      = 4;
	localparam int CMD_W      = 2;
	localparam int IN_WAY_W   = 3;
	localparam int VAL_W      = 16;
	localparam int IN_DATA_W  = ((IN_WAY_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = 16;

	// leaf key coding: 0 is minus infinity, key+1 a real key, 2^KEY_BITS+1 plus infinity
	localparam logic [LKEY_W-1:0] NEG_INF = '0;
	localparam logic [LKEY_W-1:0] POS_INF = {1'b1, {(KEY_BITS-1){1'b0}}, 1'b1};

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_POP   = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BLD_RD,
		S_BLD_WR,
		S_BLD_RPL,
		S_BLD_WAIT,
		S_POP_CHK,
		S_POP_FILL,
		S_POP_WAIT
	} top_state_t;

	typedef enum logic [1:0] {
		R_IDLE,
		R_LOAD,
		R_STEP
	} rpl_state_t;

	typedef struct packed {
		logic              clear;
		logic [LEAF_W-1:0] k;
		logic              wr_leaf;
		logic [LEAF_W-1:0] wr_idx;
		logic [LKEY_W-1:0] wr_key;
		logic              go;
		logic [LEAF_W-1:0] go_leaf;
	} tree_ctl_t;

	typedef struct packed {
		logic              busy;
		logic [LEAF_W-1:0] root_leaf;
		logic [LKEY_W-1:0] root_key;
	} tree_stat_t;

	function automatic logic [LEAF_W-1:0] clamp_ways(input logic [CFG_W-1:0] w);
		logic [LEAF_W-1:0] r;
		if (w == '0)
			r = LEAF_W'(1);
		else if (int'(w) > MAX_WAYS)
			r = LEAF_W'(MAX_WAYS);
		else
			r = LEAF_W'(w);
		return r;
	endfunction

endpackage

// ----- hdl/lt_kwm_run_mem.sv -----
module lt_kwm_run_mem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [lt_kwm_pkg::ADDR_W-1:0]   waddr,
	input  logic [lt_kwm_pkg::KEY_BITS-1:0] wdata,
	input  logic [lt_kwm_pkg::ADDR_W-1:0]   raddr,
	output logic [lt_kwm_pkg::KEY_BITS-1:0] rdata
);
	import lt_kwm_pkg::*;

	localparam int MEM_DEPTH = 1 << ADDR_W;

	// address is {run, slot}
	logic [KEY_BITS-1:0] mem [0:MEM_DEPTH-1];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/lt_kwm_replay.sv -----
module lt_kwm_replay (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lt_kwm_pkg::tree_ctl_t  ctl,
	output lt_kwm_pkg::tree_stat_t stat
);
	import lt_kwm_pkg::*;

	rpl_state_t state_q, state_d;

	logic [LKEY_W-1:0] leaf_q  [0:MAX_WAYS];
	logic [LEAF_W-1:0] loser_q [0:MAX_WAYS-1];

	logic [LEAF_W-1:0] q_q, t_q;
	logic [LKEY_W-1:0] cand_q;

	logic [WAY_W-1:0]  node_idx;
	logic [LEAF_W-1:0] other;
	logic [LEAF_W-1:0] leaf_raddr;
	logic [LKEY_W-1:0] leaf_rd;
	logic [LEAF_W:0]   t_sum;
	logic              at_root;
	logic              win_other;

	assign node_idx  = t_q[WAY_W-1:0];
	assign other     = loser_q[node_idx];
	assign at_root   = (t_q == '0) || (int'(t_q) >= MAX_WAYS);
	assign t_sum     = {1'b0, ctl.k} + {1'b0, ctl.go_leaf};

	// one leaf read port, shared by candidate load, compare and root readout
	always_comb begin
		case (state_q)
			R_LOAD:  leaf_raddr = q_q;
			R_STEP:  leaf_raddr = other;
			default: leaf_raddr = loser_q[0];
		endcase
	end

	assign leaf_rd   = leaf_q[leaf_raddr];
	// strict less: on a tie the rising candidate stays
	assign win_other = leaf_rd < cand_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			R_IDLE:  if (ctl.go) state_d = R_LOAD;
			R_LOAD:  state_d = R_STEP;
			R_STEP:  if (at_root) state_d = R_IDLE;
			default: state_d = R_IDLE;
		endcase
	end

	always_comb begin
		stat.busy      = state_q != R_IDLE;
		stat.root_leaf = loser_q[0];
		stat.root_key  = leaf_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			q_q     <= '0;
			t_q     <= '0;
			cand_q  <= '0;
			for (int j = 0; j <= MAX_WAYS; j++)
				leaf_q[j] <= POS_INF;
			for (int j = 0; j < MAX_WAYS; j++)
				loser_q[j] <= LEAF_W'(MAX_WAYS);
		end else begin
			state_q <= state_d;
			if (ctl.clear) begin
				for (int j = 0; j <= MAX_WAYS; j++)
					leaf_q[j] <= (LEAF_W'(j) == ctl.k) ? NEG_INF : POS_INF;
				for (int j = 0; j < MAX_WAYS; j++)
					loser_q[j] <= ctl.k;
			end
			if (ctl.wr_leaf)
				leaf_q[ctl.wr_idx] <= ctl.wr_key;
			case (state_q)
				R_IDLE: begin
					if (ctl.go) begin
						q_q <= ctl.go_leaf;
						t_q <= t_sum[LEAF_W:1];
					end
				end
				R_LOAD: begin
					cand_q <= leaf_rd;
				end
				R_STEP: begin
					if (at_root) begin
						loser_q[0] <= q_q;
					end else begin
						if (win_other) begin
							loser_q[node_idx] <= q_q;
							q_q               <= other;
							cand_q            <= leaf_rd;
						end
						t_q <= t_q >> 1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/loser_tree_kway_merge_unit.sv -----
// Load: next beat taken in the following cycle. Start: per merged run, the head is read
// (BLD_RD) and written to its leaf (BLD_WR); then, from the last run down to run 0, one
// replay per run (BLD_RPL, then BLD_WAIT until the replay is done). Pop: the result is
// registered in the check state (held while the output is full); input ready again after
// the check, the leaf refill read and the replay (one tree level per cycle); a pop that
// finds nothing left frees the input right after the check. Async active-low reset empties all
// runs, sets num_ways to 8 and fills the tree with plus infinity; the key memory is not cleared.
module loser_tree_kway_merge_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [lt_kwm_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // way[2:0], value[18:3], zero pad
	input  logic [lt_kwm_pkg::CMD_W-1:0]         s_axis_tuser,  // cmd[1:0]
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [lt_kwm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // merged_value[15:0]
	output logic                                 m_axis_tlast,
	output logic                                 m_axis_tuser,  // none_left
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lt_kwm_pkg::CFG_W-1:0]         cfg_data
);
	import lt_kwm_pkg::*;

	top_state_t state_q, state_d;

	logic [CFG_W-1:0]      num_ways_q;
	logic [LEAF_W-1:0]     active_q;
	logic [LEN_W-1:0]      len_q [0:MAX_WAYS-1];
	logic [LEN_W-1:0]      rp_q  [0:MAX_WAYS-1];
	logic [CNT_W-1:0]      rem_q;
	logic [WAY_W-1:0]      i_q;
	logic [WAY_W-1:0]      q_q;
	logic                  has_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tlast_q;
	logic                  m_tuser_q;

	cmd_t                  in_cmd;
	logic [WAY_W-1:0]      in_way;
	logic [VAL_W-1:0]      in_value;
	logic                  in_acc;

	tree_ctl_t             ctl;
	tree_stat_t            stat;

	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [ADDR_W-1:0]     mem_raddr;
	logic [KEY_BITS-1:0]   mem_rdata;

	logic [WAY_W-1:0]      len_idx;
	logic [WAY_W-1:0]      root_way;
	logic [LEN_W-1:0]      len_sel;
	logic [LEN_W-1:0]      rp_sel;
	logic [LEAF_W-1:0]     k_new;
	logic [LKEY_W-1:0]     fill_key;
	logic                  out_free;
	logic                  pop_bad;
	logic                  rd_avail;
	logic                  load_ok;
	logic                  last_i;

	assign in_cmd   = cmd_t'(s_axis_tuser);
	assign in_way   = WAY_W'(s_axis_tdata[IN_WAY_W-1:0]);
	assign in_value = s_axis_tdata[IN_WAY_W +: VAL_W];
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = state_q == S_IDLE;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;
	assign m_axis_tuser  = m_tuser_q;

	assign root_way = stat.root_leaf[WAY_W-1:0];

	always_comb begin
		case (state_q)
			S_BLD_RD:  len_idx = i_q;
			S_POP_CHK: len_idx = root_way;
			default:   len_idx = in_way;
		endcase
	end

	assign len_sel  = len_q[len_idx];
	assign rp_sel   = rp_q[root_way];
	assign k_new    = clamp_ways(num_ways_q);
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign rd_avail = rp_sel < len_sel;
	assign load_ok  = int'(len_sel) < RUN_DEPTH;
	assign last_i   = LEAF_W'(i_q) == (active_q - LEAF_W'(1));
	assign fill_key = has_q ? (LKEY_W'(mem_rdata) + LKEY_W'(1)) : POS_INF;
	assign pop_bad  = (rem_q == '0) || (stat.root_key == NEG_INF) ||
	                  (stat.root_key >= POS_INF) || (stat.root_leaf >= active_q);

	lt_kwm_run_mem u_run_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (KEY_BITS'(in_value)),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lt_kwm_replay u_replay (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_cmd == CMD_START)
						state_d = S_BLD_RD;
					else if (in_cmd == CMD_POP)
						state_d = S_POP_CHK;
				end
			end
			S_BLD_RD:  state_d = S_BLD_WR;
			S_BLD_WR:  state_d = last_i ? S_BLD_RPL : S_BLD_RD;
			S_BLD_RPL: state_d = S_BLD_WAIT;
			S_BLD_WAIT: begin
				if (!stat.busy)
					state_d = (i_q == '0) ? S_IDLE : S_BLD_RPL;
			end
			S_POP_CHK: begin
				if (out_free)
					state_d = pop_bad ? S_IDLE : S_POP_FILL;
			end
			S_POP_FILL: state_d = S_POP_WAIT;
			S_POP_WAIT: if (!stat.busy) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		ctl.k     = active_q;
		mem_we    = 1'b0;
		mem_waddr = {in_way, len_sel[PTR_W-1:0]};
		mem_raddr = {root_way, rp_sel[PTR_W-1:0]};
		case (state_q)
			S_IDLE: begin
				if (in_acc && in_cmd == CMD_LOAD && load_ok)
					mem_we = 1'b1;
				if (in_acc && in_cmd == CMD_START) begin
					ctl.clear = 1'b1;
					ctl.k     = k_new;
				end
			end
			S_BLD_RD: begin
				mem_raddr = {i_q, {PTR_W{1'b0}}};
			end
			S_BLD_WR: begin
				ctl.wr_leaf = 1'b1;
				ctl.wr_idx  = LEAF_W'(i_q);
				ctl.wr_key  = fill_key;
			end
			S_BLD_RPL: begin
				ctl.go      = 1'b1;
				ctl.go_leaf = LEAF_W'(i_q);
			end
			S_POP_FILL: begin
				// refill the winner's leaf and replay its path in the same beat
				ctl.wr_leaf = 1'b1;
				ctl.wr_idx  = LEAF_W'(q_q);
				ctl.wr_key  = fill_key;
				ctl.go      = 1'b1;
				ctl.go_leaf = LEAF_W'(q_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			num_ways_q <= CFG_W'(MAX_WAYS);
			active_q   <= clamp_ways(CFG_W'(MAX_WAYS));
			rem_q      <= '0;
			i_q        <= '0;
			q_q        <= '0;
			has_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
			for (int j = 0; j < MAX_WAYS; j++) begin
				len_q[j] <= '0;
				rp_q[j]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				num_ways_q <= cfg_data;
			// a new result loaded this cycle keeps valid high
			if (m_tvalid_q && m_axis_tready && !(state_q == S_POP_CHK && out_free))
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_cmd == CMD_LOAD && load_ok)
						len_q[in_way] <= len_sel + LEN_W'(1);
					if (in_acc && in_cmd == CMD_START) begin
						active_q <= k_new;
						rem_q    <= '0;
						i_q      <= '0;
					end
				end
				S_BLD_RD: begin
					// head is fetched now, so the pointer already sits past it
					rp_q[i_q] <= (len_sel != '0) ? LEN_W'(1) : '0;
					rem_q     <= rem_q + CNT_W'(len_sel);
					has_q     <= len_sel != '0;
				end
				S_BLD_WR: begin
					if (!last_i)
						i_q <= i_q + WAY_W'(1);
				end
				S_BLD_WAIT: begin
					if (!stat.busy && i_q != '0)
						i_q <= i_q - WAY_W'(1);
				end
				S_POP_CHK: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (pop_bad) begin
							rem_q     <= '0;
							m_tdata_q <= '0;
							m_tlast_q <= 1'b0;
							m_tuser_q <= 1'b1;
						end else begin
							rem_q     <= rem_q - CNT_W'(1);
							m_tdata_q <= OUT_DATA_W'(stat.root_key - LKEY_W'(1));
							m_tlast_q <= rem_q == CNT_W'(1);
							m_tuser_q <= 1'b0;
							q_q       <= root_way;
							has_q     <= rd_avail;
							if (rd_avail)
								rp_q[root_way] <= rp_sel + LEN_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
